@@ src/nps_pkg.sv @@
`default_nettype none

package nps_pkg;

  localparam int unsigned PaletteEntriesDef = 256;
  localparam int unsigned CompW = 8;
  localparam int unsigned InCompW = 10;
  localparam int unsigned IndexW = 8;
  localparam int unsigned CfgW = 9;
  localparam int unsigned SqW = 2 * CompW;
  localparam int unsigned DistW = SqW + 2;
  localparam logic [CfgW-1:0] CfgResetVal = 9'd256;
  localparam logic [CompW-1:0] CompMax = 8'd255;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StDone
  } state_e;

  typedef enum logic {
    OpWrite = 1'b0,
    OpMatch = 1'b1
  } op_e;

  typedef struct packed {
    logic [CompW-1:0] r;
    logic [CompW-1:0] g;
    logic [CompW-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic              usable;
    logic [IndexW-1:0] idx;
  } tag_t;

  function automatic logic [CompW-1:0] clamp_comp(logic signed [InCompW-1:0] v);
    logic [CompW-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({2'b00, CompMax})) begin
      res = CompMax;
    end else begin
      res = v[CompW-1:0];
    end
    return res;
  endfunction

  function automatic logic [CompW-1:0] abs_diff(logic [CompW-1:0] a, logic [CompW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

@@ src/nps_dist.sv @@
`default_nettype none

module nps_dist
  import nps_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              clear_i,
  input  wire logic              gray_i,
  input  wire rgb_t              ref_i,
  input  wire rgb_t              pal_i,
  input  wire tag_t              tag_i,
  output logic                   done_o,
  output logic [IndexW-1:0]      best_index_o
);

  tag_t             tag1_q, tag2_q;
  logic [CompW-1:0] dr_q, dg_q, db_q;
  logic [SqW-1:0]   sr_q, sg_q, sb_q;
  logic [DistW-1:0] sum;
  logic [DistW-1:0] best_dist_q;
  logic             found_q;
  logic [IndexW-1:0] best_idx_q;
  logic             done_q;
  logic             qual;

  assign qual = tag_i.usable && (!gray_i || ((pal_i.r == pal_i.g) && (pal_i.g == pal_i.b)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      done_q <= 1'b0;
      found_q <= 1'b0;
      best_idx_q <= '0;
    end else begin
      tag1_q <= '{valid: tag_i.valid, last: tag_i.last, usable: qual, idx: tag_i.idx};
      tag2_q <= tag1_q;
      done_q <= tag2_q.valid && tag2_q.last;
      if (clear_i) begin
        found_q <= 1'b0;
        best_idx_q <= '0;
      end else if (tag2_q.valid && tag2_q.usable && (!found_q || (sum < best_dist_q))) begin
        found_q <= 1'b1;
        best_idx_q <= tag2_q.idx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dr_q <= abs_diff(pal_i.r, ref_i.r);
    dg_q <= abs_diff(pal_i.g, ref_i.g);
    db_q <= abs_diff(pal_i.b, ref_i.b);
    sr_q <= SqW'(dr_q) * SqW'(dr_q);
    sg_q <= SqW'(dg_q) * SqW'(dg_q);
    sb_q <= SqW'(db_q) * SqW'(db_q);
    if (tag2_q.valid && tag2_q.usable && (!found_q || (sum < best_dist_q))) begin
      best_dist_q <= sum;
    end
  end

  assign sum = DistW'(sr_q) + DistW'(sg_q) + DistW'(sb_q);

  assign done_o = done_q;
  assign best_index_o = best_idx_q;

endmodule

`default_nettype wire

@@ src/nearest_palette_color_search.sv @@
`default_nettype none

// Nearest palette colour search. A write item stores one palette entry (clamped colour and
// usable mark) and leaves the input ready for the next item. A match item walks entries 0
// to N-1, N being entries_in_use capped at PALETTE_ENTRIES, through one distance pipeline
// at one entry per cycle. best_index is loaded once the pipeline has drained (at once when
// N is zero) and the input is ready again after the load, so a match's cost grows with N,
// set by the single distance unit. A result not yet taken holds the next match in its done
// state. A grey request (red, green and blue equal after clamping) considers only usable
// grey entries. No entry qualifying gives index 0. The input is ready only between items; a
// finished result waits in the output register while the next item is taken.
module nearest_palette_color_search
  import nps_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = PaletteEntriesDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CfgW-1:0]           cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      op_i,
  input  wire logic [IndexW-1:0]         entry_index_i,
  input  wire logic signed [InCompW-1:0] red_i,
  input  wire logic signed [InCompW-1:0] green_i,
  input  wire logic signed [InCompW-1:0] blue_i,
  input  wire logic                      usable_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [IndexW-1:0]              best_index_o
);

  localparam int unsigned IdxW = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CntW = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [CfgW-1:0] PalEntCfg = CfgW'(PALETTE_ENTRIES);

  state_e             state_q, state_d;
  logic [CfgW-1:0]    cfg_q;
  logic [CntW-1:0]    limit_q, limit_d;
  logic [IdxW-1:0]    addr_q, addr_d;
  rgb_t               ref_q, ref_d;
  logic               gray_q, gray_d;
  logic               out_valid_q, out_valid_d;
  logic [IndexW-1:0]  out_idx_q;
  logic               load_out;
  logic               clear;
  logic               issue;
  logic               last;
  logic               in_fire;
  logic               wr_en;
  logic               done;
  logic [IndexW-1:0]  best_idx;
  logic [CfgW-1:0]    cnt_sel;
  rgb_t               in_rgb;
  rgb_t               mem_q [PALETTE_ENTRIES];
  rgb_t               rd_q;
  logic [PALETTE_ENTRIES-1:0] usable_q;
  tag_t               tag0_q;

  assign in_rgb.r = clamp_comp(red_i);
  assign in_rgb.g = clamp_comp(green_i);
  assign in_rgb.b = clamp_comp(blue_i);

  assign in_fire = in_valid_i && in_ready_o;
  assign wr_en = in_fire && (op_e'(op_i) == OpWrite) && ({1'b0, entry_index_i} < PalEntCfg);
  assign cnt_sel = (cfg_q > PalEntCfg) ? PalEntCfg : cfg_q;
  assign last = (CntW'(addr_q) == (limit_q - CntW'(1)));

  always_comb begin
    state_d = state_q;
    limit_d = limit_q;
    addr_d = addr_q;
    ref_d = ref_q;
    gray_d = gray_q;
    out_valid_d = out_valid_q;
    in_ready_o = 1'b0;
    clear = 1'b0;
    issue = 1'b0;
    load_out = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (op_e'(op_i) == OpMatch)) begin
          limit_d = CntW'(cnt_sel);
          addr_d = '0;
          ref_d = in_rgb;
          gray_d = (in_rgb.r == in_rgb.g) && (in_rgb.g == in_rgb.b);
          clear = 1'b1;
          state_d = (cnt_sel == '0) ? StDone : StScan;
        end
      end
      StScan: begin
        issue = 1'b1;
        addr_d = addr_q + IdxW'(1);
        if (last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cfg_q <= CfgResetVal;
      limit_q <= '0;
      addr_q <= '0;
      gray_q <= 1'b0;
      out_valid_q <= 1'b0;
      usable_q <= '0;
      tag0_q <= '0;
    end else begin
      state_q <= state_d;
      limit_q <= limit_d;
      addr_q <= addr_d;
      gray_q <= gray_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        usable_q[entry_index_i[IdxW-1:0]] <= usable_i;
      end
      tag0_q <= '{valid: issue, last: last, usable: usable_q[addr_q], idx: IndexW'(addr_q)};
    end
  end

  always_ff @(posedge clk_i) begin
    ref_q <= ref_d;
    if (load_out) begin
      out_idx_q <= best_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[entry_index_i[IdxW-1:0]] <= in_rgb;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[addr_q];
  end

  nps_dist u_dist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (clear),
    .gray_i       (gray_q),
    .ref_i        (ref_q),
    .pal_i        (rd_q),
    .tag_i        (tag0_q),
    .done_o       (done),
    .best_index_o (best_idx)
  );

  assign out_valid_o = out_valid_q;
  assign best_index_o = out_idx_q;

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (CntW'(addr_q) < limit_q))
    else $error("scan address beyond entry count");

  a_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (state_q == StDrain))
    else $error("distance pipeline finished outside drain");

  a_best_in_palette: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, best_index_o} < PalEntCfg))
    else $error("best index outside palette");

  a_load_frees_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import nps_pkg::*;

  localparam int unsigned PalEntries = PaletteEntriesDef;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldOffCycles = 700;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned TailCycles = 300;

  typedef logic signed [InCompW-1:0] comp_in_t;

  typedef struct {
    op_e               op;
    logic [IndexW-1:0] idx;
    comp_in_t          red;
    comp_in_t          green;
    comp_in_t          blue;
    logic              usable;
  } pal_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                op_i = 1'b0;
  logic [IndexW-1:0]   entry_index_i = '0;
  comp_in_t            red_i = '0;
  comp_in_t            green_i = '0;
  comp_in_t            blue_i = '0;
  logic                usable_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [IndexW-1:0]   best_index_o;

  pal_item_t         item_q[$];
  logic [IndexW-1:0] best_index_q[$];

  bit [CompW-1:0] pal_r [PalEntries];
  bit [CompW-1:0] pal_g [PalEntries];
  bit [CompW-1:0] pal_b [PalEntries];
  bit             pal_usable [PalEntries];
  logic [CfgW-1:0] search_cfg = CfgResetVal;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_request = 0;
  int unsigned stall_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned n_writes = 0;
  int unsigned n_matches = 0;
  int unsigned n_results = 0;
  logic        in_taken = 1'b0;

  nearest_palette_color_search #(
    .PALETTE_ENTRIES(PalEntries)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .entry_index_i(entry_index_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .usable_i     (usable_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .best_index_o (best_index_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [CompW-1:0] sat_comp(comp_in_t v);
    if (v[InCompW-1]) return '0;
    if (|v[InCompW-2:CompW]) return '1;
    return v[CompW-1:0];
  endfunction

  function automatic int unsigned search_span();
    return (search_cfg > PalEntries) ? PalEntries : int'(search_cfg);
  endfunction

  function automatic logic [IndexW-1:0] nearest_entry(logic [CompW-1:0] r, logic [CompW-1:0] g,
                                                      logic [CompW-1:0] b);
    int unsigned limit, best, best_dist, d, dr, dg, db;
    limit = search_span();
    best = 0;
    if (r == g && g == b) begin
      best_dist = 256;
      for (int i = 0; i < limit; i++) begin
        if (pal_usable[i] && pal_r[i] == pal_g[i] && pal_g[i] == pal_b[i]) begin
          d = (pal_r[i] > r) ? pal_r[i] - r : r - pal_r[i];
          if (d < best_dist) begin
            best_dist = d;
            best = i;
          end
        end
      end
    end else begin
      best_dist = 1 << 24;
      for (int i = 0; i < limit; i++) begin
        if (pal_usable[i]) begin
          dr = (pal_r[i] > r) ? pal_r[i] - r : r - pal_r[i];
          dg = (pal_g[i] > g) ? pal_g[i] - g : g - pal_g[i];
          db = (pal_b[i] > b) ? pal_b[i] - b : b - pal_b[i];
          d = dr * dr + dg * dg + db * db;
          if (d < best_dist) begin
            best_dist = d;
            best = i;
          end
        end
      end
    end
    return best[IndexW-1:0];
  endfunction

  task automatic apply_item();
    logic [CompW-1:0] r, g, b;
    r = sat_comp(red_i);
    g = sat_comp(green_i);
    b = sat_comp(blue_i);
    if (op_i == OpWrite) begin
      n_writes++;
      if (entry_index_i < PalEntries) begin
        pal_r[entry_index_i] = r;
        pal_g[entry_index_i] = g;
        pal_b[entry_index_i] = b;
        pal_usable[entry_index_i] = usable_i;
      end
    end else begin
      n_matches++;
      best_index_q.push_back(nearest_entry(r, g, b));
    end
  endtask

  task automatic check_result(logic [IndexW-1:0] got);
    logic [IndexW-1:0] want;
    n_results++;
    if (best_index_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("best_index %0d arrived with nothing expected", got);
    end else begin
      want = best_index_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("best_index mismatch: expected %0d, got %0d", want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) apply_item();
    if (out_valid_o && out_ready_i) check_result(best_index_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("no handshake for %0d cycles, %0d results outstanding", StallLimit,
               best_index_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    pal_item_t it;
    if (!in_valid_i || in_taken) begin
      if (item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        it = item_q.pop_front();
        in_valid_i <= 1'b1;
        op_i <= it.op;
        entry_index_i <= it.idx;
        red_i <= it.red;
        green_i <= it.green;
        blue_i <= it.blue;
        usable_i <= it.usable;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_seen != stall_request) begin
      stall_seen = stall_request;
      hold_left = HoldOffCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic comp_in_t rand_comp();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return comp_in_t'($urandom());
    if (sel < 9) return comp_in_t'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: return comp_in_t'(-512);
      1: return comp_in_t'(-1);
      2: return comp_in_t'(0);
      3: return comp_in_t'(255);
      4: return comp_in_t'(256);
      default: return comp_in_t'(511);
    endcase
  endfunction

  function automatic pal_item_t pick_item(int unsigned span, bit want_write);
    pal_item_t it;
    int unsigned k, sel;
    it.op = want_write ? OpWrite : OpMatch;
    it.idx = IndexW'($urandom_range(0, 255));
    it.usable = 1'($urandom_range(0, 1));
    it.red = rand_comp();
    it.green = rand_comp();
    it.blue = rand_comp();
    sel = $urandom_range(0, 9);
    if (want_write) begin
      if (sel < 8) it.idx = IndexW'($urandom_range(0, span - 1));
      it.usable = ($urandom_range(0, 4) != 0);
      if (sel >= 6) begin
        it.green = it.red;
        it.blue = it.red;
      end
    end else if (sel < 3) begin
      it.green = it.red;
      it.blue = it.red;
    end else if (sel < 5) begin
      k = $urandom_range(0, span - 1);
      it.red = comp_in_t'(int'(pal_r[k]) + int'($urandom_range(0, 8)) - 4);
      it.green = comp_in_t'(int'(pal_g[k]) + int'($urandom_range(0, 8)) - 4);
      it.blue = comp_in_t'(int'(pal_b[k]) + int'($urandom_range(0, 8)) - 4);
    end
    return it;
  endfunction

  task automatic push_item(op_e op, int idx, int r, int g, int b, bit u);
    pal_item_t it;
    it.op = op;
    it.idx = IndexW'(idx);
    it.red = comp_in_t'(r);
    it.green = comp_in_t'(g);
    it.blue = comp_in_t'(b);
    it.usable = u;
    item_q.push_back(it);
  endtask

  task automatic wait_idle();
    while (item_q.size() != 0 || in_valid_i || best_index_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [CfgW-1:0] cfg_val, int unsigned send_pct,
                           int unsigned recv_pct, int unsigned n_items, bit hold_off);
    int unsigned span, warm;
    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cfg_val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    search_cfg = cfg_val;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    span = (search_span() == 0) ? PalEntries : search_span();
    warm = (span < 24) ? span : 24;
    for (int i = 0; i < n_items; i++) begin
      item_q.push_back(pick_item(span, (i < warm) || ($urandom_range(0, 99) < 35)));
    end
    if (hold_off) stall_request++;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 15;
    recv_idle_pct = 76;
    push_item(OpMatch, 255, -512, -512, -512, 1'b1);
    push_item(OpMatch, 0, 511, -1, 128, 1'b0);
    push_item(OpWrite, 0, -512, 511, 300, 1'b1);
    push_item(OpWrite, 255, 511, 511, 511, 1'b1);
    push_item(OpWrite, 128, -1, -1, -1, 1'b1);
    push_item(OpWrite, 10, 100, 100, 100, 1'b0);
    push_item(OpWrite, 20, 100, 100, 100, 1'b1);
    push_item(OpWrite, 21, 100, 100, 100, 1'b1);
    push_item(OpWrite, 30, 200, 10, 50, 1'b1);
    push_item(OpWrite, 31, 200, 10, 50, 1'b1);
    push_item(OpMatch, 0, 100, 100, 100, 1'b0);
    push_item(OpMatch, 255, -7, -300, -1, 1'b1);
    push_item(OpMatch, 0, 256, 400, 511, 1'b0);
    push_item(OpMatch, 170, 200, 10, 50, 1'b1);
    push_item(OpMatch, 85, 0, 255, 255, 1'b0);
    push_item(OpMatch, 0, 255, 0, 0, 1'b0);
    push_item(OpWrite, 20, 100, 100, 100, 1'b0);
    push_item(OpMatch, 0, 100, 100, 100, 1'b1);
    push_item(OpWrite, 128, 0, 0, 1, 1'b1);
    push_item(OpMatch, 0, 3, 3, 3, 1'b0);
    push_item(OpMatch, 255, 90, 100, 110, 1'b1);

    run_phase(9'd256, 15, 76, 110, 1'b0);
    run_phase(9'd0, 15, 76, 110, 1'b0);
    run_phase(9'd7, 15, 76, 110, 1'b1);
    run_phase(9'd511, 76, 15, 110, 1'b0);
    run_phase(9'd1, 76, 15, 110, 1'b0);
    run_phase(9'd33, 76, 15, 110, 1'b0);
    run_phase(9'd300, 0, 0, 110, 1'b0);
    run_phase(9'd2, 0, 0, 110, 1'b1);
    run_phase(9'd130, 0, 0, 110, 1'b0);

    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    $display("run covered %0d palette writes and %0d searches, %0d results checked",
             n_writes, n_matches, n_results);
    $display("entry counts 0, 1, 2, 7, 33, 130, 256, 300 and 511 under three idling patterns");
    if (mismatches == 0 && best_index_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
